/* hw/rtl/cma_pkg.sv */
// shared types and constants of the centered moving average block
package cma_pkg;

  localparam int MAX_WINDOW_DEF  = 15;
  localparam int SAMPLE_BITS_DEF = 12;

  // window register
  localparam int WIN_W = 4;
  localparam logic [WIN_W-1:0] WIN_RESET      = 4'd5;
  localparam logic [WIN_W-1:0] WIN_PASS_LIMIT = 4'd2;

  // half of a 4-bit window never needs more than three bits
  localparam int HALF_W = WIN_W - 1;

  // quotient bits resolved per divider cycle
  localparam int DIV_BITS = 4;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic pass;
    logic last;
  } cma_flags_t;

  typedef struct packed {
    logic              clear;
    logic [HALF_W-1:0] half;
  } cma_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } cma_state_e;

endpackage

/* hw/rtl/cma_front.sv */
// front end: window register, request classification and queue push
module cma_front import cma_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [WIN_W-1:0]                           cfg_wdata_i,
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  logic [SAMPLE_BITS-1:0]                     sample_i,
  input  logic                                       in_last_i,
  input  logic                                       q_full_i,
  output logic                                       q_push_o,
  output logic [SAMPLE_BITS+$bits(cma_flags_t)-1:0]  q_data_o,
  output cma_ctrl_t                                  ctrl_o
);

  localparam int HALF_MAX = (MAX_WINDOW - 1) / 2;

  logic [WIN_W-1:0]  window_q, window_d;
  logic [HALF_W-1:0] half_raw;
  cma_flags_t        flags;

  assign window_d = cfg_we_i ? cfg_wdata_i : window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WIN_RESET;
    end else begin
      window_q <= window_d;
    end
  end

  assign half_raw = window_q[WIN_W-1:1];

  always_comb begin
    ctrl_o.clear = cfg_we_i;
    // wide windows are clamped so the full span fits the history
    if (int'(half_raw) > HALF_MAX) begin
      ctrl_o.half = HALF_W'(HALF_MAX);
    end else begin
      ctrl_o.half = half_raw;
    end
  end

  always_comb begin
    flags.pass = (window_q < WIN_PASS_LIMIT);
    flags.last = in_last_i;
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;
  assign q_data_o   = {flags, sample_i};

endmodule

/* hw/rtl/cma_queue.sv */
// short request queue between front end and back end
module cma_queue import cma_pkg::*; #(
  parameter int WIDTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign data_o  = slot_q[rd_ptr_q];
  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);

endmodule

/* hw/rtl/cma_back.sv */
// back end: sample history, running window sum, divider and output register
module cma_back import cma_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  cma_ctrl_t                                  ctrl_i,
  input  logic                                       q_empty_i,
  input  logic [SAMPLE_BITS+$bits(cma_flags_t)-1:0]  q_data_i,
  output logic                                       q_pop_o,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic [SAMPLE_BITS-1:0]                     filtered_o,
  output logic                                       out_last_o
);

  localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W     = $clog2(MAX_WINDOW);
  localparam int SUM_W     = SAMPLE_BITS + CNT_W;
  localparam int DIV_STEPS = (SAMPLE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int QP        = DIV_STEPS * DIV_BITS;
  localparam int EXT_W     = QP + CNT_W;
  localparam int REM_W     = CNT_W + 1;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  cma_state_e state_q, state_d;

  cma_flags_t             flags;
  logic [SAMPLE_BITS-1:0] sample;

  logic [SAMPLE_BITS-1:0] hist_q [MAX_WINDOW];
  logic [CNT_W-1:0]       rd_idx;
  logic [SAMPLE_BITS-1:0] hist_rd;

  logic [CNT_W-1:0] half_c, span, span_m1;
  logic [CNT_W-1:0] rc_q, rc_inc, pend_q, pend_inc;
  logic [SUM_W-1:0] sum_q, sum_inc;
  logic [SAMPLE_BITS-1:0] drop;

  logic [SUM_W-1:0] work_sum_q;
  logic [CNT_W-1:0] hi_q, d_q, d_dec, target;
  logic             flush_q, more, shrink;

  logic [EXT_W-1:0]  ext;
  logic [REM_W-1:0]  rem_q, rem_nx;
  logic [QP-1:0]     low_q, low_nx;
  logic [CNT_W-1:0]  den_q;
  logic [STEP_W-1:0] step_q;
  logic              div_last;

  logic out_valid_q, out_last_q, out_free;
  logic [SAMPLE_BITS-1:0] filtered_q;

  logic pop, take_filter, emit_now, out_load, step_flush;

  assign {flags, sample} = q_data_i;

  assign half_c  = CNT_W'(ctrl_i.half);
  assign span    = CNT_W'({half_c, 1'b1});
  assign span_m1 = CNT_W'({half_c, 1'b0});

  // single history read port: oldest in-span entry while idle, flush tap otherwise
  assign rd_idx  = (state_q == ST_IDLE) ? span_m1 : hi_q;
  assign hist_rd = hist_q[rd_idx[IDX_W-1:0]];

  assign rc_inc   = (rc_q < span) ? rc_q + 1'b1 : rc_q;
  assign pend_inc = (pend_q <= half_c) ? pend_q + 1'b1 : pend_q;
  assign drop     = (rc_q == span) ? hist_rd : '0;
  assign sum_inc  = sum_q + SUM_W'(sample) - SUM_W'(drop);

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign more     = flush_q & (d_q != '0);
  assign d_dec    = d_q - 1'b1;
  assign target   = d_dec + half_c;
  assign shrink   = (hi_q > target);
  assign div_last = (step_q == STEP_W'(DIV_STEPS - 1));
  assign ext      = EXT_W'(work_sum_q);

  // fsm outputs
  always_comb begin
    pop         = (state_q == ST_IDLE) & ~q_empty_i & (~flags.pass | out_free);
    take_filter = pop & ~flags.pass;
    emit_now    = take_filter & (flags.last | (pend_inc > half_c));
    out_load    = (pop & flags.pass) | ((state_q == ST_DONE) & out_free);
    step_flush  = (state_q == ST_DONE) & out_free & more;
  end

  // fsm next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (emit_now) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: state_d = ST_DIV;
      ST_DIV: begin
        if (div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = more ? ST_PREP : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // frame counters and running sum of the in-span history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q   <= '0;
      pend_q <= '0;
      sum_q  <= '0;
    end else if (ctrl_i.clear || (pop && (flags.pass || flags.last))) begin
      rc_q   <= '0;
      pend_q <= '0;
      sum_q  <= '0;
    end else if (take_filter) begin
      rc_q   <= rc_inc;
      sum_q  <= sum_inc;
      pend_q <= emit_now ? pend_inc - 1'b1 : pend_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_filter) begin
      hist_q[0] <= sample;
      for (int k = 1; k < MAX_WINDOW; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

  // result job: prefix sum, top tap and results still owed in a flush
  always_ff @(posedge clk_i) begin
    if (emit_now) begin
      work_sum_q <= sum_inc;
      hi_q       <= rc_inc - 1'b1;
      d_q        <= pend_inc - 1'b1;
      flush_q    <= flags.last;
    end else if (step_flush) begin
      d_q <= d_dec;
      // the window of the next newer result loses its oldest-side top tap
      if (shrink) begin
        hi_q       <= hi_q - 1'b1;
        work_sum_q <= work_sum_q - SUM_W'(hist_rd);
      end
    end
  end

  // restoring divider, quotient shifts in behind the dividend bits
  always_comb begin
    rem_nx = rem_q;
    low_nx = low_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_nx = {rem_nx[REM_W-2:0], low_nx[QP-1]};
      low_nx = {low_nx[QP-2:0], 1'b0};
      if (rem_nx >= REM_W'(den_q)) begin
        rem_nx    = rem_nx - REM_W'(den_q);
        low_nx[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_PREP: begin
        // upper part is below the divisor since the mean fits a sample
        rem_q  <= REM_W'(ext[EXT_W-1:QP]);
        low_q  <= ext[QP-1:0];
        den_q  <= hi_q + 1'b1;
        step_q <= '0;
      end
      ST_DIV: begin
        rem_q  <= rem_nx;
        low_q  <= low_nx;
        step_q <= step_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (state_q == ST_DONE) begin
        filtered_q <= low_q[SAMPLE_BITS-1:0];
        out_last_q <= flush_q & (d_q == '0);
      end else begin
        filtered_q <= sample;
        out_last_q <= flags.last;
      end
    end
  end

  assign q_pop_o     = pop;
  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign out_last_o  = out_last_q;

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= half_c + 1'b1)
    else $error("owed result count above half span plus one");

  a_rc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc_q <= span)
    else $error("received count above window span");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && div_last |=> state_q == ST_DONE)
    else $error("divider did not finish after its last step");

  a_flush_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) && flush_q |-> hi_q >= d_q)
    else $error("flush top tap fell below result offset");

endmodule

/* hw/rtl/centered_moving_average_frame.sv */
// top level of the centered moving average filter over a sample frame
//
//   channel   direction  handshake               payload
//   in        request    in_valid_i/in_stall_o   sample_i, in_last_i
//   out       result     out_valid_o/out_stall_i filtered_o, out_last_o
//   cfg       write      cfg_we_i                cfg_wdata_i (window length)
//
// a request is taken into a two-entry queue; the back end handles a request that owes
// no result or passes through while idle, and a filtered result then goes through prep,
// a 4-bit-per-cycle divider and output load, which holds while the output stalls.
// a flush on the last sample gives its owed results one after another, each the same way.
// reset clears counters, the window length to 5 and the queue; history needs no clear.
// output stalls hold the result register; the queue keeps taking requests until full.
module centered_moving_average_frame import cma_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [WIN_W-1:0]       cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   in_last_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0] filtered_o,
  output logic                   out_last_o
);

  localparam int ENTRY_W = SAMPLE_BITS + $bits(cma_flags_t);

  logic               q_push, q_pop, q_full, q_empty;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;
  cma_ctrl_t          ctrl;

  cma_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .in_last_i   (in_last_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata),
    .ctrl_o      (ctrl)
  );

  cma_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  cma_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o),
    .out_last_o  (out_last_o)
  );

endmodule
